// File: hdl/sdv_pkg.sv
// Shared types, constants and codes of the snare drum voice.
`timescale 1ns / 1ps

package sdv_pkg;

    // Fixed-point format and derived widths.
    localparam int FRAC_BITS = 24;
    localparam int OUT_SHIFT = FRAC_BITS - 14;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 3;
    localparam int VEL_W     = 25;
    localparam int NOISE_W   = 26;
    localparam int SAMPLE_W  = 16;

    localparam logic signed [DATA_W-1:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

    // Register reset values.
    localparam logic [25:0] RST_BODY_FREQ1 = 26'd439216;
    localparam logic [25:0] RST_BODY_FREQ2 = 26'd781780;
    localparam logic [25:0] RST_SNAP_FREQ  = 26'd4379700;
    localparam logic [25:0] RST_BODY_DAMP  = 26'd2796203;
    localparam logic [25:0] RST_SNAP_DAMP  = 26'd11184811;
    localparam logic [24:0] RST_BODY_DECAY = 25'd16775760;
    localparam logic [24:0] RST_SNAP_DECAY = 25'd16774303;
    localparam logic [24:0] RST_SNAP_GAIN  = 25'd8388608;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BODY_FREQ1 = 3'd0,
        CFG_BODY_FREQ2 = 3'd1,
        CFG_SNAP_FREQ  = 3'd2,
        CFG_BODY_DAMP  = 3'd3,
        CFG_SNAP_DAMP  = 3'd4,
        CFG_BODY_DECAY = 3'd5,
        CFG_SNAP_DECAY = 3'd6,
        CFG_SNAP_GAIN  = 3'd7
    } t_cfg_idx;

    // Sequencer steps.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B1_F,
        ST_B1_Q,
        ST_B1_H,
        ST_B1_B,
        ST_B2_Q,
        ST_B2_H,
        ST_B2_B,
        ST_S_Q,
        ST_S_H,
        ST_S_B,
        ST_BODY,
        ST_BENV,
        ST_SNAP,
        ST_SENV,
        ST_MIXB,
        ST_MIXS,
        ST_MIXADD,
        ST_OUT
    } t_state;

    // Operand pairs of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_F1_B1BAND,
        MUL_QB_B1BAND,
        MUL_F1_HIGH,
        MUL_F2_B2BAND,
        MUL_QB_B2BAND,
        MUL_F2_HIGH,
        MUL_FS_SBAND,
        MUL_QS_SBAND,
        MUL_FS_HIGH,
        MUL_BODY_BENV,
        MUL_BENV_DB,
        MUL_SBAND_SENV,
        MUL_SENV_DS,
        MUL_BODY_BG,
        MUL_SNAP_SG
    } t_mul_sel;

    // Register updates that consume the product.
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_B1LOW_ADD,
        ALU_B1_HIGH,
        ALU_B1BAND_ADD,
        ALU_B2LOW_ADD,
        ALU_B2_HIGH,
        ALU_B2BAND_ADD,
        ALU_SLOW_ADD,
        ALU_S_HIGH_BODY,
        ALU_SBAND_ADD,
        ALU_BODY_LOAD,
        ALU_BENV_LOAD,
        ALU_SNAP_LOAD,
        ALU_SENV_LOAD,
        ALU_MIX_LOAD,
        ALU_MIX_ADD
    } t_alu_op;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic     in_ready;
        logic     out_load;
        t_mul_sel mul_sel;
        t_alu_op  alu_op;
    } t_ctrl;

endpackage

// File: hdl/sdv_mac.sv
// Shared fixed-point multiplier with a registered, rescaled product.
`timescale 1ns / 1ps

module sdv_mac
    import sdv_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_prod
);

    logic signed [2*DATA_W-1:0] w_full;
    logic signed [DATA_W-1:0]   r_prod;

    // Full product, then floor shift by the fraction width and wrap to 32 bits.
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end

    assign o_prod = r_prod;

endmodule

// File: hdl/sdv_seq.sv
// Step sequencer that drives the shared multiplier and the register updates.
`timescale 1ns / 1ps

module sdv_seq
    import sdv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_free,
    output t_state o_state,
    output t_ctrl  o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next step: a fixed walk through the schedule, holding at the end while
    // the output register is still full.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_B1_F;
            ST_B1_F:   n_state = ST_B1_Q;
            ST_B1_Q:   n_state = ST_B1_H;
            ST_B1_H:   n_state = ST_B1_B;
            ST_B1_B:   n_state = ST_B2_Q;
            ST_B2_Q:   n_state = ST_B2_H;
            ST_B2_H:   n_state = ST_B2_B;
            ST_B2_B:   n_state = ST_S_Q;
            ST_S_Q:    n_state = ST_S_H;
            ST_S_H:    n_state = ST_S_B;
            ST_S_B:    n_state = ST_BODY;
            ST_BODY:   n_state = ST_BENV;
            ST_BENV:   n_state = ST_SNAP;
            ST_SNAP:   n_state = ST_SENV;
            ST_SENV:   n_state = ST_MIXB;
            ST_MIXB:   n_state = ST_MIXS;
            ST_MIXS:   n_state = ST_MIXADD;
            ST_MIXADD: n_state = ST_OUT;
            ST_OUT:    if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Per-step controls. Most steps issue one product, consume the product
    // issued in the step before, or both.
    always_comb begin
        o_ctrl = '{in_ready: 1'b0, out_load: 1'b0, mul_sel: MUL_NONE, alu_op: ALU_NONE};
        case (r_state)
            ST_IDLE:   o_ctrl.in_ready = 1'b1;
            ST_B1_F:   o_ctrl.mul_sel = MUL_F1_B1BAND;
            ST_B1_Q: begin
                o_ctrl.mul_sel = MUL_QB_B1BAND;
                o_ctrl.alu_op  = ALU_B1LOW_ADD;
            end
            ST_B1_H: begin
                o_ctrl.mul_sel = MUL_F2_B2BAND;
                o_ctrl.alu_op  = ALU_B1_HIGH;
            end
            ST_B1_B: begin
                o_ctrl.mul_sel = MUL_F1_HIGH;
                o_ctrl.alu_op  = ALU_B2LOW_ADD;
            end
            ST_B2_Q: begin
                o_ctrl.mul_sel = MUL_QB_B2BAND;
                o_ctrl.alu_op  = ALU_B1BAND_ADD;
            end
            ST_B2_H: begin
                o_ctrl.mul_sel = MUL_FS_SBAND;
                o_ctrl.alu_op  = ALU_B2_HIGH;
            end
            ST_B2_B: begin
                o_ctrl.mul_sel = MUL_F2_HIGH;
                o_ctrl.alu_op  = ALU_SLOW_ADD;
            end
            ST_S_Q: begin
                o_ctrl.mul_sel = MUL_QS_SBAND;
                o_ctrl.alu_op  = ALU_B2BAND_ADD;
            end
            ST_S_H:    o_ctrl.alu_op = ALU_S_HIGH_BODY;
            ST_S_B:    o_ctrl.mul_sel = MUL_FS_HIGH;
            ST_BODY: begin
                o_ctrl.mul_sel = MUL_BODY_BENV;
                o_ctrl.alu_op  = ALU_SBAND_ADD;
            end
            ST_BENV: begin
                o_ctrl.mul_sel = MUL_BENV_DB;
                o_ctrl.alu_op  = ALU_BODY_LOAD;
            end
            ST_SNAP: begin
                o_ctrl.mul_sel = MUL_SBAND_SENV;
                o_ctrl.alu_op  = ALU_BENV_LOAD;
            end
            ST_SENV: begin
                o_ctrl.mul_sel = MUL_SENV_DS;
                o_ctrl.alu_op  = ALU_SNAP_LOAD;
            end
            ST_MIXB: begin
                o_ctrl.mul_sel = MUL_BODY_BG;
                o_ctrl.alu_op  = ALU_SENV_LOAD;
            end
            ST_MIXS: begin
                o_ctrl.mul_sel = MUL_SNAP_SG;
                o_ctrl.alu_op  = ALU_MIX_LOAD;
            end
            ST_MIXADD: o_ctrl.alu_op = ALU_MIX_ADD;
            ST_OUT:    o_ctrl.out_load = i_out_free;
            default:   o_ctrl.in_ready = 1'b0;
        endcase
    end

    assign o_state = r_state;

endmodule

// File: hdl/snare_drum_voice_svf.sv
// Top level of the snare drum voice: registers, datapath and stream ports.
`timescale 1ns / 1ps

// Snare drum voice built from two Chamberlin state-variable body resonators
// and a noise band-pass, all in signed Q24 fixed point. Each input transaction
// produces one 16-bit output sample: an idle step accepts the transaction,
// then eighteen sequencer steps follow, set by the single shared 32x32
// multiplier that computes the fifteen dependent products one per cycle with
// its product registered. If the previous sample has not been taken, the last
// step holds until the output register is free. Configuration registers are
// written through a simple write port, by the user only while idle (unenforced).

module snare_drum_voice_svf
    import sdv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [55:0]          i_s_axis_tdata,   // [24:0] velocity, [50:25] noise_sample
    input  logic [0:0]           i_s_axis_tuser,   // [0] trigger
    // Output stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata    // [15:0] audio_sample
);

    // Configuration registers.
    logic [25:0] r_f1, r_f2, r_fs, r_qb, r_qs;
    logic [24:0] r_db, r_ds, r_sg;

    // Filter and envelope state.
    logic signed [DATA_W-1:0] r_b1_low, r_b1_band, r_b2_low, r_b2_band;
    logic signed [DATA_W-1:0] r_s_low, r_s_band, r_benv, r_senv;

    // Per-sample working registers.
    logic signed [DATA_W-1:0] r_imp, r_noise, r_high, r_body, r_snap, r_mix;
    logic [SAMPLE_W-1:0]      r_out_data;
    logic                     r_out_valid;

    t_ctrl                    w_ctrl;
    t_state                   w_state;
    logic                     w_in_acc;
    logic                     w_out_free;
    logic signed [DATA_W-1:0] w_a, w_b, w_prod;
    logic signed [DATA_W-1:0] w_vel, w_vel_raw, w_sg_raw, w_sg, w_bg;
    logic signed [DATA_W-1:0] w_mix_sum, w_scaled;
    logic signed [DATA_W:0]   w_bsum;
    logic [SAMPLE_W-1:0]      w_sat;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    sdv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_state    (w_state),
        .o_ctrl     (w_ctrl)
    );

    sdv_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Configuration writes; every index of the three-bit address is a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= RST_BODY_FREQ1;
            r_f2 <= RST_BODY_FREQ2;
            r_fs <= RST_SNAP_FREQ;
            r_qb <= RST_BODY_DAMP;
            r_qs <= RST_SNAP_DAMP;
            r_db <= RST_BODY_DECAY;
            r_ds <= RST_SNAP_DECAY;
            r_sg <= RST_SNAP_GAIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BODY_FREQ1: r_f1 <= i_cfg_wdata;
                CFG_BODY_FREQ2: r_f2 <= i_cfg_wdata;
                CFG_SNAP_FREQ:  r_fs <= i_cfg_wdata;
                CFG_BODY_DAMP:  r_qb <= i_cfg_wdata;
                CFG_SNAP_DAMP:  r_qs <= i_cfg_wdata;
                CFG_BODY_DECAY: r_db <= i_cfg_wdata[VEL_W-1:0];
                CFG_SNAP_DECAY: r_ds <= i_cfg_wdata[VEL_W-1:0];
                CFG_SNAP_GAIN:  r_sg <= i_cfg_wdata[VEL_W-1:0];
                default:        r_sg <= r_sg;
            endcase
        end
    end

    // Velocity and snap gain are limited to 1.0; body gain is the remainder.
    assign w_vel_raw = {{(DATA_W-VEL_W){1'b0}}, i_s_axis_tdata[VEL_W-1:0]};
    assign w_vel     = (w_vel_raw > FX_ONE) ? FX_ONE : w_vel_raw;
    assign w_sg_raw  = {{(DATA_W-VEL_W){1'b0}}, r_sg};
    assign w_sg      = (w_sg_raw > FX_ONE) ? FX_ONE : w_sg_raw;
    assign w_bg      = FX_ONE - w_sg;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (w_ctrl.mul_sel)
            MUL_F1_B1BAND:  begin w_a = r_b1_band; w_b = {6'b0, r_f1}; end
            MUL_QB_B1BAND:  begin w_a = r_b1_band; w_b = {6'b0, r_qb}; end
            MUL_F1_HIGH:    begin w_a = r_high;    w_b = {6'b0, r_f1}; end
            MUL_F2_B2BAND:  begin w_a = r_b2_band; w_b = {6'b0, r_f2}; end
            MUL_QB_B2BAND:  begin w_a = r_b2_band; w_b = {6'b0, r_qb}; end
            MUL_F2_HIGH:    begin w_a = r_high;    w_b = {6'b0, r_f2}; end
            MUL_FS_SBAND:   begin w_a = r_s_band;  w_b = {6'b0, r_fs}; end
            MUL_QS_SBAND:   begin w_a = r_s_band;  w_b = {6'b0, r_qs}; end
            MUL_FS_HIGH:    begin w_a = r_high;    w_b = {6'b0, r_fs}; end
            MUL_BODY_BENV:  begin w_a = r_body;    w_b = r_benv;       end
            MUL_BENV_DB:    begin w_a = r_benv;    w_b = {7'b0, r_db}; end
            MUL_SBAND_SENV: begin w_a = r_s_band;  w_b = r_senv;       end
            MUL_SENV_DS:    begin w_a = r_senv;    w_b = {7'b0, r_ds}; end
            MUL_BODY_BG:    begin w_a = r_body;    w_b = w_bg;         end
            MUL_SNAP_SG:    begin w_a = r_snap;    w_b = w_sg;         end
            default:        begin w_a = '0;        w_b = '0;           end
        endcase
    end

    // Average of the two body band outputs, floor halved.
    assign w_bsum = {r_b1_band[DATA_W-1], r_b1_band} + {r_b2_band[DATA_W-1], r_b2_band};

    // Final mix, floor shift and saturation to the sample width.
    assign w_mix_sum = r_mix + w_prod;
    assign w_scaled  = r_mix >>> OUT_SHIFT;
    always_comb begin
        if (w_scaled > 32'sd32767) begin
            w_sat = 16'h7FFF;
        end else if (w_scaled < -32'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_scaled[SAMPLE_W-1:0];
        end
    end

    // Filter and envelope state, updated by the sequencer steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_low  <= '0;
            r_b1_band <= '0;
            r_b2_low  <= '0;
            r_b2_band <= '0;
            r_s_low   <= '0;
            r_s_band  <= '0;
            r_benv    <= '0;
            r_senv    <= '0;
        end else if (w_in_acc) begin
            // A hit restarts both envelopes before this sample.
            if (i_s_axis_tuser[0]) begin
                r_benv <= FX_ONE;
                r_senv <= w_vel;
            end
        end else begin
            case (w_ctrl.alu_op)
                ALU_B1LOW_ADD:  r_b1_low  <= r_b1_low + w_prod;
                ALU_B1BAND_ADD: r_b1_band <= r_b1_band + w_prod;
                ALU_B2LOW_ADD:  r_b2_low  <= r_b2_low + w_prod;
                ALU_B2BAND_ADD: r_b2_band <= r_b2_band + w_prod;
                ALU_SLOW_ADD:   r_s_low   <= r_s_low + w_prod;
                ALU_SBAND_ADD:  r_s_band  <= r_s_band + w_prod;
                ALU_BENV_LOAD:  r_benv    <= w_prod;
                ALU_SENV_LOAD:  r_senv    <= w_prod;
                default:        r_benv    <= r_benv;
            endcase
        end
    end

    // Per-sample working values.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            // The impulse is three times the velocity on a hit, else zero.
            r_imp   <= i_s_axis_tuser[0] ? (w_vel + (w_vel <<< 1)) : '0;
            r_noise <= {{(DATA_W-NOISE_W){i_s_axis_tdata[50]}}, i_s_axis_tdata[50:25]};
        end
        case (w_ctrl.alu_op)
            ALU_B1_HIGH: r_high <= r_imp - r_b1_low - w_prod;
            ALU_B2_HIGH: r_high <= r_imp - r_b2_low - w_prod;
            ALU_S_HIGH_BODY: begin
                r_high <= r_noise - r_s_low - w_prod;
                r_body <= w_bsum[DATA_W:1];
            end
            ALU_BODY_LOAD: r_body <= w_prod;
            ALU_SNAP_LOAD: r_snap <= w_prod;
            ALU_MIX_LOAD:  r_mix  <= w_prod;
            ALU_MIX_ADD:   r_mix  <= w_mix_sum;
            default:       r_snap <= r_snap;
        endcase
    end

    // Output register; it frees as soon as the sample is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_out_data <= w_sat;
        end
    end

    assign o_s_axis_tready = w_ctrl.in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // An accepted sample keeps the voice busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("voice ready right after accepting a sample");

    // A new output sample appears only out of the final step.
    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_state == ST_OUT))
        else $error("output valid raised outside the final step");

    // A hit restarts the body envelope at 1.0.
    a_hit_loads_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tuser[0]) |=> (r_benv == FX_ONE))
        else $error("body envelope not restarted by a hit");

    // The output register is never overwritten while a sample waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("output sample overwritten before it was taken");

endmodule

// File: sim/tb_snare_drum_voice_svf.sv
// Self-checking testbench of the snare drum voice with a sample-accurate fixed-point predictor.
`timescale 1ns / 1ps

module tb_snare_drum_voice_svf;
    import sdv_pkg::*;

    localparam longint      Q_ONE         = longint'(1) << FRAC_BITS;
    localparam int unsigned VEL_UNITY     = 1 << FRAC_BITS;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam int          SHOW_LIMIT    = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [55:0]          i_s_axis_tdata = '0;   // [24:0] velocity, [50:25] noise_sample
    logic [0:0]           i_s_axis_tuser = '0;   // [0] trigger
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [15:0]          o_m_axis_tdata;        // [15:0] audio_sample

    // Idling percentages of the current phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Scoreboard.
    logic [15:0] expected_samples[$];
    int          error_count   = 0;
    int          samples_seen  = 0;
    int          items_sent    = 0;
    int          hits_sent     = 0;

    // Predictor copy of the registers and the voice state.
    logic [25:0]        coef[8];
    logic signed [31:0] res1_lp, res1_bp, res2_lp, res2_bp;
    logic signed [31:0] snap_lp, snap_bp;
    logic signed [31:0] body_env, snap_env, kick_imp;

    snare_drum_voice_svf dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("tb_snare_drum_voice_svf: FAIL");
        $finish;
    end

    // Fixed-point product: full product, floor shift, wrap to 32 bits.
    function automatic logic signed [31:0] q_mul(longint a, longint b);
        longint prod;
        prod = (a * b) >>> FRAC_BITS;
        return prod[31:0];
    endfunction

    // One Chamberlin state-variable filter update.
    function automatic void svf_update(inout logic signed [31:0] lp, inout logic signed [31:0] bp,
                                       input logic signed [31:0] x, input logic [25:0] f,
                                       input logic [25:0] q);
        logic signed [31:0] hp;
        lp = lp + q_mul(f, bp);
        hp = x - lp - q_mul(q, bp);
        bp = bp + q_mul(f, hp);
    endfunction

    // Return predictor registers and state to their reset values.
    function automatic void reset_voice_model();
        coef[CFG_BODY_FREQ1] = RST_BODY_FREQ1;
        coef[CFG_BODY_FREQ2] = RST_BODY_FREQ2;
        coef[CFG_SNAP_FREQ]  = RST_SNAP_FREQ;
        coef[CFG_BODY_DAMP]  = RST_BODY_DAMP;
        coef[CFG_SNAP_DAMP]  = RST_SNAP_DAMP;
        coef[CFG_BODY_DECAY] = {1'b0, RST_BODY_DECAY};
        coef[CFG_SNAP_DECAY] = {1'b0, RST_SNAP_DECAY};
        coef[CFG_SNAP_GAIN]  = {1'b0, RST_SNAP_GAIN};
        res1_lp = '0; res1_bp = '0; res2_lp = '0; res2_bp = '0;
        snap_lp = '0; snap_bp = '0;
        body_env = '0; snap_env = '0; kick_imp = '0;
    endfunction

    // Advance the predicted voice by one sample and return the output.
    function automatic logic [15:0] predict_sample(logic trig, logic [24:0] vel,
                                                   logic signed [25:0] noise);
        longint             v;
        longint             gain;
        longint             scaled;
        logic signed [31:0] imp;
        logic signed [31:0] body;
        logic signed [31:0] snap;
        logic signed [31:0] mix;
        logic signed [31:0] noise_ext;
        noise_ext = noise;
        if (trig) begin
            v = vel;
            if (v > Q_ONE) begin
                v = Q_ONE;
            end
            kick_imp = 32'(v * 3);
            body_env = 32'(Q_ONE);
            snap_env = 32'(v);
        end
        imp = kick_imp;
        kick_imp = '0;

        // Body resonators and envelope.
        svf_update(res1_lp, res1_bp, imp, coef[CFG_BODY_FREQ1], coef[CFG_BODY_DAMP]);
        svf_update(res2_lp, res2_bp, imp, coef[CFG_BODY_FREQ2], coef[CFG_BODY_DAMP]);
        scaled = (longint'(res1_bp) + longint'(res2_bp)) >>> 1;
        body = scaled[31:0];
        body = q_mul(body, body_env);
        body_env = q_mul(body_env, coef[CFG_BODY_DECAY]);

        // Snap band-pass and envelope.
        svf_update(snap_lp, snap_bp, noise_ext, coef[CFG_SNAP_FREQ], coef[CFG_SNAP_DAMP]);
        snap = q_mul(snap_bp, snap_env);
        snap_env = q_mul(snap_env, coef[CFG_SNAP_DECAY]);

        // Mix, scale and saturate.
        gain = coef[CFG_SNAP_GAIN];
        if (gain > Q_ONE) begin
            gain = Q_ONE;
        end
        mix = q_mul(body, Q_ONE - gain) + q_mul(snap, gain);
        scaled = longint'(mix) >>> OUT_SHIFT;
        if (scaled > 32767) begin
            scaled = 32767;
        end
        if (scaled < -32768) begin
            scaled = -32768;
        end
        return scaled[15:0];
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < SHOW_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Receiver readiness, redrawn every cycle.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Output checker: each sample against the oldest expectation.
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h", o_m_axis_tdata));
            end else begin
                want = expected_samples.pop_front();
                if (o_m_axis_tdata !== want) begin
                    report_mismatch($sformatf("sample %0d: audio_sample got %h, want %h",
                                              samples_seen, o_m_axis_tdata, want));
                end
            end
        end
    end

    // Send one input transaction, idling at random first.
    task automatic send_item(logic trig, logic [24:0] vel, logic signed [25:0] noise);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= trig;
        i_s_axis_tdata  <= {5'b0, noise, vel};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_samples.push_back(predict_sample(trig, vel, noise));
        items_sent++;
        if (trig) begin
            hits_sent++;
        end
    endtask

    // Drop valid and wait until every expected sample has come out.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Register write; only called while the voice is idle.
    task automatic write_reg(t_cfg_idx idx, logic [25:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_BODY_DECAY || idx == CFG_SNAP_DECAY || idx == CFG_SNAP_GAIN) begin
            coef[idx] = {1'b0, val[24:0]};
        end else begin
            coef[idx] = val;
        end
    endtask

    // Wait for idle, then write the whole register set.
    task automatic program_voice(logic [25:0] f1, logic [25:0] f2, logic [25:0] fs,
                                 logic [25:0] qb, logic [25:0] qs, logic [25:0] db,
                                 logic [25:0] ds, logic [25:0] sg);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_BODY_FREQ1, f1);
        write_reg(CFG_BODY_FREQ2, f2);
        write_reg(CFG_SNAP_FREQ, fs);
        write_reg(CFG_BODY_DAMP, qb);
        write_reg(CFG_SNAP_DAMP, qs);
        write_reg(CFG_BODY_DECAY, db);
        write_reg(CFG_SNAP_DECAY, ds);
        write_reg(CFG_SNAP_GAIN, sg);
    endtask

    // Mostly plausible coefficient, sometimes any 26-bit pattern.
    function automatic logic [25:0] pick_coef(int unsigned typical_max);
        if ($urandom_range(3) == 0) begin
            return 26'($urandom);
        end
        return 26'($urandom_range(typical_max));
    endfunction

    function automatic logic [25:0] pick_decay();
        if ($urandom_range(4) == 0) begin
            return 26'($urandom);
        end
        return 26'(VEL_UNITY - $urandom_range(40000));
    endfunction

    // Hits, retriggers and silence under the reset-time registers.
    task automatic test_directed_hits();
        send_item(1'b0, 25'd0, 26'sd0);
        send_item(1'b1, 25'd0, 26'sd0);
        send_item(1'b0, 25'd0, 26'sd0);
        send_item(1'b1, 25'(VEL_UNITY), 26'sd0);
        send_item(1'b0, 25'd0, 26'sh1FFFFFF);
        send_item(1'b0, 25'd0, 26'sh2000000);
        send_item(1'b0, 25'd0, 26'sd0);
        send_item(1'b0, 25'd0, -26'sd1);
        // Velocity above unity saturates to 1.0.
        send_item(1'b1, 25'h1FFFFFF, 26'sh1FFFFFF);
        send_item(1'b0, 25'd0, 26'sh2000000);
        send_item(1'b0, 25'd0, 26'sh1FFFFFF);
        send_item(1'b0, 25'd0, 26'sh2000000);
        // Retrigger while both envelopes are still ringing.
        send_item(1'b1, 25'h0800000, 26'sd1);
        // Velocity without a trigger is ignored.
        send_item(1'b0, 25'h1FFFFFF, 26'($urandom));
        send_item(1'b0, 25'h1555555, 26'($urandom));
        send_item(1'b0, 25'h0AAAAAA, 26'($urandom));
    endtask

    // Full hit with loud alternating noise under the current registers.
    task automatic loud_hit(int ticks);
        send_item(1'b1, 25'(VEL_UNITY), 26'sh1FFFFFF);
        for (int n = 0; n < ticks; n++) begin
            send_item(1'b0, 25'd0, n[0] ? 26'sh2000000 : 26'sh1FFFFFF);
        end
    endtask

    // Register extremes: zero, range limits and every bit set.
    task automatic test_register_extremes();
        program_voice('0, '0, '0, '0, '0, '0, '0, '0);
        loud_hit(12);
        // Coefficients at 2.0, unity decay and snap gain at 1.0.
        program_voice(26'h2000000, 26'h2000000, 26'h2000000, 26'h2000000, 26'h2000000,
                      26'(VEL_UNITY), 26'(VEL_UNITY), 26'(VEL_UNITY));
        loud_hit(12);
        // All ones: oversized coefficients, wrapping state, snap gain above 1.0.
        program_voice('1, '1, '1, '1, '1, '1, '1, '1);
        loud_hit(12);
    endtask

    // Random hits and decays under random registers and one idling profile.
    task automatic test_random_phase(int send_pct, int recv_pct, int count, bit hold_off);
        logic              trig;
        logic [24:0]       vel;
        logic signed [25:0] noise;
        program_voice(pick_coef(VEL_UNITY >> 1), pick_coef(VEL_UNITY >> 1),
                      pick_coef(VEL_UNITY), pick_coef(VEL_UNITY << 1),
                      pick_coef(VEL_UNITY << 1), pick_decay(), pick_decay(),
                      pick_coef(VEL_UNITY));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            trig  = (n == 0) || ($urandom_range(23) == 0);
            vel   = ($urandom_range(7) == 0) ? 25'($urandom) : 25'($urandom_range(VEL_UNITY));
            noise = ($urandom_range(3) == 0) ? 26'(int'($urandom_range(2000)) - 1000)
                                             : 26'($urandom);
            // Sender holds off until the pipeline is empty.
            if (hold_off && n == count / 2) begin
                wait_for_drain();
            end
            send_item(trig, vel, noise);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Test sequence.
    initial begin
        int guard;
        reset_voice_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_hits();
        test_register_extremes();
        test_random_phase(0, 0, 140, 1'b0);
        test_random_phase(88, 0, 130, 1'b1);
        test_random_phase(0, 88, 130, 1'b0);
        test_random_phase(8, 8, 140, 1'b0);

        // Let the last samples out, then watch for strays.
        wait_for_drain();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        guard = expected_samples.size();
        if (guard != 0) begin
            report_mismatch($sformatf("%0d expected samples never came out", guard));
        end

        $display("Covered %0d input transactions with %0d hits and %0d checked samples,",
                 items_sent, hits_sent, samples_seen);
        $display("over register extremes and four sender/receiver idling profiles.");
        if (error_count == 0) begin
            $display("tb_snare_drum_voice_svf: PASS");
        end else begin
            $display("tb_snare_drum_voice_svf: FAIL");
        end
        $finish;
    end

endmodule
